### design/signed_count_rle_decoder_unit_macros.svh
// Assertion macros for the signed-count RLE decoder.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SIGNED_COUNT_RLE_DECODER_UNIT_MACROS_SVH
`define SIGNED_COUNT_RLE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define SCRLED_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scrled assertion failed");

// Next-cycle implication.
`define SCRLED_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scrled assertion failed");

`endif

### design/scrled_pkg.sv
// Shared types and constants for the signed-count RLE decoder.
// No dependencies.
package scrled_pkg;

	localparam int BYTES_PER_RESULT_DEF = 4;
	localparam int TOTAL_WIDTH_DEF      = 24;
	localparam int MAX_LANES            = 4;
	localparam int QUEUE_DEPTH          = 2;
	localparam int DATA_W               = 64;
	localparam int USER_W               = 2;
	localparam int USER_STREAM_END      = 0;
	localparam int USER_TRUNCATED       = 1;
	localparam logic [23:0] FIELD_MAX   = 24'hFF_FFFF;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_VALUE   = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] val;
		logic [7:0] cnt;
		logic       last;
		logic       trunc;
	} cmd_t;

endpackage

### design/scrled_front.sv
// Front end: parses headers and turns value and literal bytes (and a last byte) into decode commands.
// Depends on scrled_pkg.
module scrled_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output scrled_pkg::cmd_t  cmd
);

	scrled_pkg::phase_t phase_q, phase_d;
	logic [7:0]         left_q, left_d;
	logic               value_hit, lit_hit, accept;

	assign value_hit = (phase_q == scrled_pkg::PH_VALUE) && (left_q != 8'd0);
	assign lit_hit   = (phase_q == scrled_pkg::PH_LITERAL) && (left_q != 8'd0);
	assign in_ready  = cmd_ready;
	assign accept    = in_valid && cmd_ready;

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		priority if (value_hit) begin
			phase_d = scrled_pkg::PH_HEADER;
			left_d  = 8'd0;
		end else if (lit_hit) begin
			left_d = left_q - 8'd1;
			if (left_q == 8'd1) begin
				phase_d = scrled_pkg::PH_HEADER;
			end
		end else if (in_byte[7]) begin
			left_d  = 8'(9'd257 - {1'b0, in_byte});
			phase_d = scrled_pkg::PH_VALUE;
		end else begin
			left_d  = in_byte + 8'd1;
			phase_d = scrled_pkg::PH_LITERAL;
		end
	end

	always_comb begin
		cmd.val   = in_byte;
		cmd.cnt   = value_hit ? left_q : (lit_hit ? 8'd1 : 8'd0);
		cmd.last  = in_last;
		cmd.trunc = (phase_d != scrled_pkg::PH_HEADER);
		cmd_valid = in_valid && ((cmd.cnt != 8'd0) || in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= scrled_pkg::PH_HEADER;
			left_q  <= 8'd0;
		end else if (accept) begin
			if (in_last) begin
				phase_q <= scrled_pkg::PH_HEADER;
				left_q  <= 8'd0;
			end else begin
				phase_q <= phase_d;
				left_q  <= left_d;
			end
		end
	end

endmodule

### design/scrled_queue.sv
// Short command queue between front and back end.
// Depends on scrled_pkg.
module scrled_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  scrled_pkg::cmd_t  push_cmd,
	output logic              full,
	output logic              head_valid,
	output scrled_pkg::cmd_t  head_cmd,
	input  logic              pop
);

	localparam int Depth = scrled_pkg::QUEUE_DEPTH;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	scrled_pkg::cmd_t  slots_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   fill_q;
	logic              do_push, do_pop;

	assign full       = (fill_q == CntW'(Depth));
	assign head_valid = (fill_q != '0);
	assign head_cmd   = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + CntW'(1);
				2'b01:   fill_q <= fill_q - CntW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### design/scrled_back.sv
// Back end: expands commands into packed output words, keeps the total.
// Depends on scrled_pkg.
module scrled_back #(
	parameter int BYTES_PER_RESULT = scrled_pkg::BYTES_PER_RESULT_DEF,
	parameter int TOTAL_WIDTH      = scrled_pkg::TOTAL_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  scrled_pkg::cmd_t                head_cmd,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [scrled_pkg::DATA_W-1:0]   m_tdata,
	output logic                            m_tlast,
	output logic [scrled_pkg::USER_W-1:0]   m_tuser
);

	localparam int Lanes = (BYTES_PER_RESULT > scrled_pkg::MAX_LANES) ? scrled_pkg::MAX_LANES :
		((BYTES_PER_RESULT < 1) ? 1 : BYTES_PER_RESULT);

	logic [7:0]             sent_q, rem;
	logic [TOTAL_WIDTH-1:0] total_q, total_sat;
	logic [TOTAL_WIDTH:0]   total_sum;
	logic [32:0]            total_ext;
	logic                   slot_free, emit, fin;
	logic [2:0]             n;

	logic                   valid_q;
	logic [7:0]             lane_q [scrled_pkg::MAX_LANES];
	logic [2:0]             count_q;
	logic                   run_end_q, stream_end_q, trunc_q;
	logic [23:0]            shown_q;

	assign slot_free = !valid_q || m_tready;
	assign emit      = head_valid && slot_free;
	assign rem       = head_cmd.cnt - sent_q;
	assign fin       = (rem <= 8'(Lanes));
	assign n         = fin ? rem[2:0] : 3'(Lanes);
	assign pop       = emit && fin;

	assign total_sum = {1'b0, total_q} + (TOTAL_WIDTH + 1)'(n);
	assign total_sat = total_sum[TOTAL_WIDTH] ? '1 : total_sum[TOTAL_WIDTH-1:0];
	assign total_ext = 33'(total_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q  <= 8'd0;
			total_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				sent_q  <= fin ? 8'd0 : sent_q + 8'(Lanes);
				total_q <= (fin && head_cmd.last) ? '0 : total_sat;
			end
			if (slot_free) begin
				valid_q <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			for (int j = 0; j < scrled_pkg::MAX_LANES; j++) begin
				lane_q[j] <= (3'(j) < n) ? head_cmd.val : 8'd0;
			end
			count_q      <= n;
			run_end_q    <= fin;
			stream_end_q <= fin && head_cmd.last;
			trunc_q      <= fin && head_cmd.last && head_cmd.trunc;
			shown_q      <= (total_ext > 33'(scrled_pkg::FIELD_MAX)) ?
				scrled_pkg::FIELD_MAX : total_ext[23:0];
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = scrled_pkg::DATA_W'({shown_q, count_q,
		lane_q[3], lane_q[2], lane_q[1], lane_q[0]});
	assign m_tlast  = run_end_q;
	always_comb begin
		m_tuser = '0;
		m_tuser[scrled_pkg::USER_STREAM_END] = stream_end_q;
		m_tuser[scrled_pkg::USER_TRUNCATED]  = trunc_q;
	end

endmodule

### design/signed_count_rle_decoder_unit.sv
// Signed-count RLE decoder top level: front parser, 2-entry command queue, back expander.
// A decoded command passes through the queue register and the back end's output register.
// Throughput: 1 input byte per cycle for headers and literals; a repeat of k bytes is split
// over ceil(k/lanes) output words, lanes being BYTES_PER_RESULT held to 1..4,
// and input stalls once the queue fills.
// Reset (arst_n low): parser to header phase, queue empty, total zero, output invalid.
module signed_count_rle_decoder_unit #(
	parameter int BYTES_PER_RESULT = scrled_pkg::BYTES_PER_RESULT_DEF,
	parameter int TOTAL_WIDTH      = scrled_pkg::TOTAL_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // in_byte
	input  logic                           s_tlast,  // in_last
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_byte0, out_byte1, out_byte2, out_byte3, out_count, total_bytes, zero pad
	output logic [scrled_pkg::DATA_W-1:0]  m_tdata,
	output logic                           m_tlast,  // run_end
	output logic [scrled_pkg::USER_W-1:0]  m_tuser   // stream_end, truncated
);

	`include "signed_count_rle_decoder_unit_macros.svh"

	scrled_pkg::cmd_t front_cmd, head_cmd;
	logic             front_valid, q_full, head_valid, pop;

	scrled_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.cmd_valid (front_valid),
		.cmd_ready (!q_full),
		.cmd       (front_cmd)
	);

	scrled_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid),
		.push_cmd   (front_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	scrled_back #(
		.BYTES_PER_RESULT (BYTES_PER_RESULT),
		.TOTAL_WIDTH      (TOTAL_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	`SCRLED_ASSERT_IMP(a_end_is_run_end, m_tvalid && m_tuser[scrled_pkg::USER_STREAM_END], m_tlast)
	`SCRLED_ASSERT_IMP(a_trunc_on_end, m_tvalid && m_tuser[scrled_pkg::USER_TRUNCATED], m_tuser[scrled_pkg::USER_STREAM_END])
	`SCRLED_ASSERT_IMP(a_empty_is_status, m_tvalid && (m_tdata[34:32] == 3'd0), m_tuser[scrled_pkg::USER_STREAM_END])
	`SCRLED_ASSERT_NXT(a_end_clears_total, pop && head_cmd.last, u_back.total_q == '0)

endmodule
